// ===== src/color_threshold_centroid_top_assert.svh =====
// Assertion macros shared by the color threshold centroid RTL
`ifndef COLOR_THRESHOLD_CENTROID_TOP_ASSERT_SVH
`define COLOR_THRESHOLD_CENTROID_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define CTC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define CTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/ctc_pkg.sv =====
// Package with widths, constants and sequencer states of the centroid block
`default_nettype none

package ctc_pkg;

  localparam int COLOR_W  = 8;
  localparam int COLUMN_W = 10;
  localparam int CENTER_W = 11;
  localparam int SUM_W    = 32;
  localparam int COUNT_W  = 20;
  localparam int QUOT_W   = 10;
  localparam int DEN_W    = COUNT_W + 3;
  localparam int REM_W    = DEN_W + QUOT_W;
  localparam int CTR_W    = 4;

  localparam logic [COLOR_W-1:0] MARGIN_RESET = 8'd30;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 20'hFFFFF;
  // 205 / 1024 approximates 1/5 exactly enough for values below 1024
  localparam logic [7:0]         RECIP5       = 8'd205;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== src/ctc_if.sv =====
// Handshake interfaces for the pixel input and the result output channels
`default_nettype none

interface ctc_pix_if;
  logic                               valid;
  logic                               ready;
  logic [ctc_pkg::COLOR_W-1:0]        blue;
  logic [ctc_pkg::COLOR_W-1:0]        green;
  logic [ctc_pkg::COLOR_W-1:0]        red;
  logic [ctc_pkg::COLUMN_W-1:0]       column;
  logic                               frame_end;

  modport source (output valid, blue, green, red, column, frame_end, input ready);
  modport sink   (input valid, blue, green, red, column, frame_end, output ready);
endinterface

interface ctc_res_if;
  logic                               valid;
  logic                               ready;
  logic                               mask;
  logic signed [ctc_pkg::CENTER_W-1:0] center;
  logic                               center_updated;
  logic                               frame_done;

  modport source (output valid, mask, center, center_updated, frame_done, input ready);
  modport sink   (input valid, mask, center, center_updated, frame_done, output ready);
endinterface

`default_nettype wire

// ===== src/color_threshold_centroid_top.sv =====
// Color threshold with column centroid tracking over a pixel stream
//
// Usage: pixels enter on in_ch (BGR, column, frame_end) with a valid/ready
// handshake; one result per pixel leaves on out_ch (mask, center,
// center_updated, frame_done). A pixel is marked when red > green + margin;
// cfg_we/cfg_wdata set the margin and must only be used while idle.
// An ordinary pixel, and a frame end with at most one marked pixel, gives
// its result in the cycle after acceptance, so such pixels stream at one
// per cycle while the receiver keeps up. A frame end with two or more marked
// pixels runs a setup state, a restoring divider that retires one quotient
// bit per cycle and an update state, and in_ch.ready stays low meanwhile.
// Reset clears sum and count, sets the margin to 30 and the center to
// ceil(COLUMNS/2)-1. Results sit in an output register: a new pixel is
// taken while that register is empty or being drained, so a stalled
// receiver stalls the input after one waiting result. No item is lost.
`default_nettype none

module color_threshold_centroid_top #(
  parameter int COLUMNS = 320
) (
  input  wire                          clk,
  input  wire                          rst_n,
  ctc_pix_if.sink                      in_ch,
  ctc_res_if.source                    out_ch,
  input  wire                          cfg_we,
  input  wire [ctc_pkg::COLOR_W-1:0]   cfg_wdata
);

  `include "color_threshold_centroid_top_assert.svh"

  localparam logic signed [ctc_pkg::CENTER_W-1:0] CENTER_RESET =
    ctc_pkg::CENTER_W'((COLUMNS + 1) / 2 - 1);

  ctc_pkg::state_t                     state_r;
  logic [ctc_pkg::COLOR_W-1:0]         margin_r;
  logic [ctc_pkg::SUM_W-1:0]           sum_r;
  logic [ctc_pkg::COUNT_W-1:0]         count_r;
  logic signed [ctc_pkg::CENTER_W-1:0] center_r;
  logic [ctc_pkg::REM_W-1:0]           rem_r;
  logic [ctc_pkg::DEN_W-1:0]           den_r;
  logic [ctc_pkg::QUOT_W-1:0]          q_r;
  logic [ctc_pkg::CTR_W-1:0]           ctr_r;
  logic [7:0]                          div5_r;
  logic                                mask_r;

  logic                                out_valid_r;
  logic                                out_mask_r;
  logic signed [ctc_pkg::CENTER_W-1:0] out_center_r;
  logic                                out_updated_r;
  logic                                out_done_r;

  logic                                accept;
  logic                                mark;
  logic                                acc;
  logic                                start_div;
  logic                                out_load;
  logic [ctc_pkg::SUM_W-1:0]           sum_acc;
  logic [ctc_pkg::COUNT_W-1:0]         count_acc;
  logic [ctc_pkg::DEN_W-1:0]           den5;
  logic [ctc_pkg::REM_W-1:0]           num_init;
  logic [ctc_pkg::REM_W-1:0]           trial;
  logic [17:0]                         prod5;
  logic [7:0]                          div5;
  logic signed [ctc_pkg::CENTER_W-1:0] center_new;

  // Accept a pixel when idle and the output register is free or draining
  assign in_ch.ready = (state_r == ctc_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Color test and accumulation with saturation at a full count
  assign mark      = {1'b0, in_ch.red} > ({1'b0, in_ch.green} + {1'b0, margin_r});
  assign acc       = mark && (count_r != ctc_pkg::COUNT_MAX);
  assign sum_acc   = sum_r + (acc ? {{(ctc_pkg::SUM_W-ctc_pkg::COLUMN_W){1'b0}}, in_ch.column}
                                  : '0);
  assign count_acc = count_r + {{(ctc_pkg::COUNT_W-1){1'b0}}, acc};

  // Start the divider on a frame end with two or more marked pixels
  assign start_div = in_ch.frame_end && (count_acc > ctc_pkg::COUNT_W'(1));
  assign out_load  = (accept && !start_div) || (state_r == ctc_pkg::S_DONE);

  // Divider setup: den = 5*count, num = 4*sum + den - 1 (sum stays below 2^30)
  assign den5     = {1'b0, count_r, 2'b00} + {3'b000, count_r};
  assign num_init = {sum_r[ctc_pkg::REM_W-3:0], 2'b00}
                  + {{ctc_pkg::QUOT_W{1'b0}}, den5} - ctc_pkg::REM_W'(1);

  // Shared subtract-and-compare unit operand
  assign trial = {{ctc_pkg::QUOT_W{1'b0}}, den_r} << ctr_r;

  // trunc(center/5) by reciprocal multiply; a negative center gives zero
  assign prod5 = {8'b0, center_r[ctc_pkg::COLUMN_W-1:0]} * {10'b0, ctc_pkg::RECIP5};
  assign div5  = center_r[ctc_pkg::CENTER_W-1] ? 8'd0 : prod5[17:10];

  assign center_new = $signed({3'b000, div5_r}) + $signed({1'b0, q_r})
                    - ctc_pkg::CENTER_W'(1);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= ctc_pkg::MARGIN_RESET;
    end else if (cfg_we) begin
      margin_r <= cfg_wdata;
    end
  end

  // Output valid: set on a new result, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctc_pkg::S_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      center_r    <= CENTER_RESET;
      ctr_r       <= '0;
    end else begin
      unique case (state_r)
        ctc_pkg::S_IDLE: begin
          if (accept) begin
            if (start_div) begin
              sum_r   <= sum_acc;
              count_r <= count_acc;
              mask_r  <= mark;
              state_r <= ctc_pkg::S_PREP;
            end else begin
              out_mask_r    <= mark;
              out_center_r  <= center_r;
              out_updated_r <= 1'b0;
              out_done_r    <= in_ch.frame_end;
              sum_r         <= in_ch.frame_end ? '0 : sum_acc;
              count_r       <= in_ch.frame_end ? '0 : count_acc;
            end
          end
        end
        ctc_pkg::S_PREP: begin
          rem_r   <= num_init;
          den_r   <= den5;
          q_r     <= '0;
          ctr_r   <= ctc_pkg::CTR_W'(ctc_pkg::QUOT_W - 1);
          div5_r  <= div5;
          sum_r   <= '0;
          count_r <= '0;
          state_r <= ctc_pkg::S_DIV;
        end
        ctc_pkg::S_DIV: begin
          // retire one quotient bit
          if (rem_r >= trial) begin
            rem_r      <= rem_r - trial;
            q_r[ctr_r] <= 1'b1;
          end
          if (ctr_r == '0) begin
            state_r <= ctc_pkg::S_DONE;
          end else begin
            ctr_r <= ctr_r - ctc_pkg::CTR_W'(1);
          end
        end
        ctc_pkg::S_DONE: begin
          center_r      <= center_new;
          out_mask_r    <= mask_r;
          out_center_r  <= center_new;
          out_updated_r <= 1'b1;
          out_done_r    <= 1'b1;
          state_r       <= ctc_pkg::S_IDLE;
        end
        default: begin
          state_r <= ctc_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mask           = out_mask_r;
  assign out_ch.center         = out_center_r;
  assign out_ch.center_updated = out_updated_r;
  assign out_ch.frame_done     = out_done_r;

  // Checks on the sequencer and the divider
  `CTC_ASSERT(a_state_onehot, $onehot(state_r), "sequencer state not one-hot")
  `CTC_ASSERT_IMP(a_busy_not_ready, state_r != ctc_pkg::S_IDLE, !in_ch.ready,
    "pixel accepted while dividing")
  `CTC_ASSERT_IMP(a_div_cleared, state_r == ctc_pkg::S_DIV,
    (sum_r == '0) && (count_r == '0), "accumulators not cleared during divide")
  `CTC_ASSERT_IMP(a_rem_bound, state_r == ctc_pkg::S_DIV,
    rem_r < ({{ctc_pkg::QUOT_W{1'b0}}, den_r} << (ctr_r + ctc_pkg::CTR_W'(1))),
    "divider remainder out of range")
  `CTC_ASSERT_IMP(a_update_at_end, out_ch.valid && out_ch.center_updated,
    out_ch.frame_done, "center updated without frame end")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the color threshold centroid block: directed and random pixel streams
`timescale 1ns / 100ps

module tb_top;

  localparam int COLUMNS     = 320;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [ctc_pkg::COLOR_W-1:0]  blue;
    logic [ctc_pkg::COLOR_W-1:0]  green;
    logic [ctc_pkg::COLOR_W-1:0]  red;
    logic [ctc_pkg::COLUMN_W-1:0] column;
    logic                         frame_end;
  } pixel_t;

  typedef struct {
    logic                                mask;
    logic signed [ctc_pkg::CENTER_W-1:0] center;
    logic                                updated;
    logic                                done;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ctc_pkg::COLOR_W-1:0] cfg_wdata = '0;

  ctc_pix_if pix_ch ();
  ctc_res_if res_ch ();

  color_threshold_centroid_top #(
    .COLUMNS(COLUMNS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pix_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Pixels waiting to be offered and results the block still owes
  pixel_t      pixel_q[$];
  pix_result_t due_results[$];

  // Predicted block state
  logic [ctc_pkg::COLOR_W-1:0] margin_cur = ctc_pkg::MARGIN_RESET;
  logic [ctc_pkg::SUM_W-1:0]   col_sum = '0;
  logic [ctc_pkg::COUNT_W-1:0] mark_cnt = '0;
  int                          center_now = (COLUMNS + 1) / 2 - 1;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  stall_req = 0;
  int  stall_seen = 0;
  int  hold_left = 0;
  bit  pix_taken = 1'b0;
  int  quiet_cycles = 0;
  int  n_pixels = 0;
  int  n_results = 0;
  int  n_frames = 0;
  int  n_updates = 0;
  int  n_errors = 0;

  task automatic report_mismatch(string what, int idx, int exp_v, int got_v);
    $display("ERROR result %0d: %s expected %0d got %0d", idx, what, exp_v, got_v);
    n_errors++;
  endtask

  // Mark the pixel, accumulate it and smooth the center on a frame end with two or more marked pixels
  function automatic pix_result_t track_pixel(logic [ctc_pkg::COLOR_W-1:0] g,
                                              logic [ctc_pkg::COLOR_W-1:0] r,
                                              logic [ctc_pkg::COLUMN_W-1:0] col,
                                              logic fe);
    pix_result_t res;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] up;
    logic        hit;
    hit = int'(r) > int'(g) + int'(margin_cur);
    res.updated = 1'b0;
    if (hit && mark_cnt < ctc_pkg::COUNT_MAX) begin
      col_sum  = col_sum + col;
      mark_cnt = mark_cnt + 1'b1;
    end
    if (fe) begin
      n_frames++;
      if (mark_cnt > 1) begin
        num = 64'(col_sum) * 4;
        den = 64'(mark_cnt) * 5;
        up  = (num + den - 1) / den;
        center_now = center_now / 5 + int'(up) - 1;
        res.updated = 1'b1;
        n_updates++;
      end
      col_sum  = '0;
      mark_cnt = '0;
    end
    res.mask   = hit;
    res.center = center_now[ctc_pkg::CENTER_W-1:0];
    res.done   = fe;
    return res;
  endfunction

  task automatic push_pixel(int b, int g, int r, int col, bit fe);
    pixel_t p;
    p.blue      = b[ctc_pkg::COLOR_W-1:0];
    p.green     = g[ctc_pkg::COLOR_W-1:0];
    p.red       = r[ctc_pkg::COLOR_W-1:0];
    p.column    = col[ctc_pkg::COLUMN_W-1:0];
    p.frame_end = fe;
    pixel_q.push_back(p);
  endtask

  // Queue raster-ordered frames with random content; a few frames are noise
  task automatic queue_frames(int n_items, int margin);
    int left;
    int len;
    int width;
    int col;
    int kind;
    int g;
    int r;
    bit noisy;
    bit fe;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
      if (len > left) len = left;
      noisy = ($urandom_range(9) == 0);
      width = $urandom_range(1024, 2);
      col   = $urandom_range(width - 1);
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(99);
        if (kind < 45 && margin < 255) begin
          g = $urandom_range(254 - margin);
          r = $urandom_range(255, g + margin + 1);
        end else if (kind < 55) begin
          g = $urandom_range(255 - margin);
          r = g + margin;
        end else begin
          g = $urandom_range(255);
          r = $urandom_range(255);
        end
        fe = (i == len - 1) || (noisy && $urandom_range(7) == 0);
        push_pixel($urandom_range(255), g, r,
                   noisy ? $urandom_range(1023) : col, fe);
        col = (col + 1) % width;
      end
      left -= len;
    end
  endtask

  // Hold until nothing is queued, offered or owed, then move to a falling edge
  task automatic wait_idle();
    while (pixel_q.size() != 0 || pix_ch.valid || due_results.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_margin(int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[ctc_pkg::COLOR_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pixel driver: hold the current item until taken, then offer the next or idle
  always @(negedge clk) begin
    pixel_t nx;
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nx = pixel_q.pop_front();
        pix_ch.blue      <= nx.blue;
        pix_ch.green     <= nx.green;
        pix_ch.red       <= nx.red;
        pix_ch.column    <= nx.column;
        pix_ch.frame_end <= nx.frame_end;
        pix_ch.valid     <= 1'b1;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_req != stall_seen) begin
      res_ch.ready <= 1'b0;
      hold_left  = HOLD_CYCLES - 1;
      stall_seen = stall_seen + 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted pixel, check each accepted result
  always @(posedge clk) begin
    pix_result_t exp_r;
    bit          res_taken;
    if (!rst_n) begin
      pix_taken = 1'b0;
    end else begin
      pix_taken = pix_ch.valid && pix_ch.ready;
      res_taken = res_ch.valid && res_ch.ready;
      if (pix_taken) begin
        due_results.push_back(track_pixel(pix_ch.green, pix_ch.red, pix_ch.column,
                                          pix_ch.frame_end));
        n_pixels++;
      end
      if (res_taken) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result, frame_done", n_results, 0,
                          res_ch.frame_done);
        end else begin
          exp_r = due_results.pop_front();
          if (res_ch.mask !== exp_r.mask)
            report_mismatch("mask", n_results, exp_r.mask, res_ch.mask);
          if (res_ch.center !== exp_r.center)
            report_mismatch("center", n_results, int'(exp_r.center), int'(res_ch.center));
          if (res_ch.center_updated !== exp_r.updated)
            report_mismatch("center_updated", n_results, exp_r.updated,
                            res_ch.center_updated);
          if (res_ch.frame_done !== exp_r.done)
            report_mismatch("frame_done", n_results, exp_r.done, res_ch.frame_done);
        end
        n_results++;
      end
      if (cfg_we) margin_cur = cfg_wdata;
      // Watchdog on cycles without any handshake
      if (pix_taken || res_taken) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int m_mid;
    int m_last;
    pix_ch.valid     = 1'b0;
    pix_ch.blue      = '0;
    pix_ch.green     = '0;
    pix_ch.red       = '0;
    pix_ch.column    = '0;
    pix_ch.frame_end = 1'b0;
    res_ch.ready     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset margin
    send_idle_pct = 32;
    recv_idle_pct = 54;
    push_pixel(0, 0, 255, 1023, 0);        // full red, last column
    push_pixel(255, 255, 0, 0, 0);         // full green, never marked
    push_pixel('hAA, 100, 130, 5, 0);      // red equals green plus margin
    push_pixel('h55, 100, 131, 6, 0);      // one above the margin
    push_pixel(255, 0, 31, 7, 1);          // frame end with three marked
    push_pixel(0, 200, 10, 100, 1);        // frame end with none marked
    push_pixel(0, 0, 200, 500, 0);         // frame with a single marked pixel
    push_pixel(0, 0, 0, 501, 1);
    // Drive the center down to column zero and below
    repeat (5) begin
      push_pixel(0, 0, 255, 0, 0);
      push_pixel(0, 0, 255, 0, 1);
    end
    // Recover from a negative center at the far right
    push_pixel(0, 0, 255, 1023, 0);
    push_pixel(15, 0, 255, 1023, 1);

    wait_idle();
    write_margin(0);
    queue_frames(350, 0);

    wait_idle();
    send_idle_pct = 54;
    recv_idle_pct = 32;
    write_margin(255);
    queue_frames(50, 255);

    wait_idle();
    m_mid = $urandom_range(254, 1);
    write_margin(m_mid);
    queue_frames(300, m_mid);

    // No idling, with one long receiver hold-off to back up the input
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    m_last = $urandom_range(254, 1);
    write_margin(m_last);
    stall_req = stall_req + 1;
    queue_frames(350, m_last);

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_results.size() != 0)
      report_mismatch("results never delivered", n_results, due_results.size(), 0);

    $display("Checked %0d results for %0d pixels over %0d frame ends, %0d center updates",
             n_results, n_pixels, n_frames, n_updates);
    $display("Margins 30, 0, 255, %0d, %0d; mixed stalls and one long output hold-off",
             m_mid, m_last);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
